FILE: rtl/core/ppts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point projection package
// Shared widths, fixed-point constants and the sequencer state type.
// ----------------------------------------------------------------------------
package ppts_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAT_DEPTH = 16;
    localparam int IDX_W     = $clog2(MAT_DEPTH);

    // Dividend of the perspective divide is |clip| scaled by one.
    localparam int DIV_W = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int Q_W   = DIV_W + 1;
    localparam int QS_W  = Q_W + 1;

    // Four terms of 2*DATA_W-FRAC_BITS bits each.
    localparam int ACC_W = 2 * DATA_W - FRAC_BITS + 2;
    localparam int SAT_W = (ACC_W > QS_W) ? ACC_W : QS_W;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_PROJECT = 1'b1;

    localparam logic signed [DATA_W-1:0] FIX_ONE =
        {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ACC,
        S_DIV,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/point_projection_to_screen.sv
`timescale 1ns / 1ps
`default_nettype none
// Timing: a load beat is written at acceptance. A project beat runs twelve
// multiply-accumulates (read, multiply, accumulate), then two 48-step divides by
// clip w, then loads the output register. Behind-camera points skip the divides.
// Throughput: one load per cycle while idle; after a project beat no new beat is
// taken until its result is loaded, which waits while a held result stalls.
// Reset spares the RAM.
// ----------------------------------------------------------------------------
// Point projection to screen
// Multiplies a world point by a stored 4x4 fixed-point matrix, divides by w
// and maps the result to top-left normalized screen coordinates.
// ----------------------------------------------------------------------------
module point_projection_to_screen (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output      logic                                in_ready,
    input  wire logic                                func,
    input  wire logic [ppts_pkg::IDX_W-1:0]          matrix_index,
    input  wire logic signed [ppts_pkg::DATA_W-1:0]  matrix_value,
    input  wire logic signed [ppts_pkg::DATA_W-1:0]  point_x,
    input  wire logic signed [ppts_pkg::DATA_W-1:0]  point_y,
    input  wire logic signed [ppts_pkg::DATA_W-1:0]  point_z,
    output      logic                                out_valid,
    input  wire logic                                out_ready,
    output      logic signed [ppts_pkg::DATA_W-1:0]  screen_x,
    output      logic signed [ppts_pkg::DATA_W-1:0]  screen_y,
    output      logic                                behind_camera
);

    import ppts_pkg::*;

    function automatic logic signed [DATA_W-1:0] sat_fix(input logic signed [SAT_W-1:0] v);
        logic all_zero;
        logic all_one;
        all_zero = (v[SAT_W-1:DATA_W-1] == '0);
        all_one  = (v[SAT_W-1:DATA_W-1] == '1);
        if (all_zero || all_one)
        begin
            return v[DATA_W-1:0];
        end
        return v[SAT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    function automatic logic [DIV_W-1:0] div_load(input logic signed [DATA_W-1:0] c);
        logic [DATA_W-1:0] m;
        m = c[DATA_W-1] ? DATA_W'(-c) : DATA_W'(c);
        return {m, {FRAC_BITS{1'b0}}};
    endfunction

    state_t state_reg, state_next;

    logic [1:0]       col_reg;
    logic [1:0]       rcnt_reg;
    logic             div_sel_reg;
    logic [CNT_W-1:0] bit_cnt_reg;
    logic             out_valid_reg;

    logic signed [DATA_W-1:0]   x_reg, y_reg, z_reg;
    logic signed [DATA_W-1:0]   cx_reg, cy_reg, cw_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [DIV_W-1:0]           dq_reg;
    logic [DATA_W-1:0]          rem_reg;
    logic                       neg_reg;
    logic signed [DATA_W-1:0]   res_x_reg, res_y_reg;
    logic                       res_behind_reg;
    logic signed [DATA_W-1:0]   screen_x_reg, screen_y_reg;
    logic                       behind_reg;

    logic                       in_fire;
    logic                       ram_re;
    logic                       out_load;
    logic [DATA_W-1:0]          ram_rdata;
    logic [1:0]                 row;
    logic signed [DATA_W-1:0]   coord;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [DATA_W-1:0]   clip_sat;
    logic                       row_last;
    logic                       cw_pos;
    logic [DATA_W-1:0]          div_trial;
    logic                       div_ge;
    logic [DATA_W-1:0]          rem_next;
    logic [DIV_W-1:0]           dq_next;
    logic                       div_last;
    logic signed [Q_W-1:0]      q_mag;
    logic signed [Q_W-1:0]      q_val;
    logic signed [QS_W-1:0]     sum_x, sum_y;
    logic signed [DATA_W-1:0]   sx_val, sy_val;

    assign in_fire = in_valid && in_ready;

    // Rows 0, 1 and 3 of the matrix feed clip x, y and w.
    assign row = {rcnt_reg[1], rcnt_reg[1] | rcnt_reg[0]};

    ppts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAT_DEPTH)
    ) u_matrix_ram (
        .clk   (clk),
        .we    (in_fire && (func == FUNC_LOAD)),
        .waddr (matrix_index),
        .wdata (matrix_value),
        .re    (ram_re),
        .raddr ({col_reg, row}),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        case (col_reg)
            2'd0:    coord = x_reg;
            2'd1:    coord = y_reg;
            2'd2:    coord = z_reg;
            default: coord = FIX_ONE;
        endcase
    end

    // The translation column multiplies by one, so its floor shift is exact.
    assign acc_sum  = acc_reg + ACC_W'(prod_reg >>> FRAC_BITS);
    assign clip_sat = sat_fix(SAT_W'(acc_sum));
    assign row_last = (col_reg == 2'd3);
    assign cw_pos   = !clip_sat[DATA_W-1] && (clip_sat != '0);

    // Restoring divide, one quotient bit per cycle; clip w is known positive.
    assign div_trial = {rem_reg[DATA_W-2:0], dq_reg[DIV_W-1]};
    assign div_ge    = (div_trial >= $unsigned(cw_reg));
    assign rem_next  = div_ge ? div_trial - $unsigned(cw_reg) : div_trial;
    assign dq_next   = {dq_reg[DIV_W-2:0], div_ge};
    assign div_last  = (bit_cnt_reg == CNT_W'(DIV_W - 1));

    assign q_mag  = {1'b0, dq_next};
    assign q_val  = neg_reg ? -q_mag : q_mag;
    assign sum_x  = QS_W'(q_val) + QS_W'(FIX_ONE);
    assign sum_y  = QS_W'(FIX_ONE) - QS_W'(q_val);
    assign sx_val = sat_fix(SAT_W'(sum_x >>> 1));
    assign sy_val = sat_fix(SAT_W'(sum_y >>> 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (func == FUNC_PROJECT))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (!row_last || (rcnt_reg != 2'd2))
                begin
                    state_next = S_READ;
                end
                else if (cw_pos)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_last && div_sel_reg)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        ram_re   = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_READ:  ram_re   = 1'b1;
            S_OUT:   out_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            rcnt_reg      <= '0;
            div_sel_reg   <= 1'b0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE)
            begin
                col_reg  <= '0;
                rcnt_reg <= '0;
            end
            else if (state_reg == S_ACC)
            begin
                col_reg <= col_reg + 2'd1;
                if (row_last)
                begin
                    rcnt_reg <= rcnt_reg + 2'd1;
                end
                div_sel_reg <= 1'b0;
                bit_cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                if (div_last)
                begin
                    bit_cnt_reg <= '0;
                    div_sel_reg <= 1'b1;
                end
                else
                begin
                    bit_cnt_reg <= bit_cnt_reg + CNT_W'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg   <= point_x;
            y_reg   <= point_y;
            z_reg   <= point_z;
            acc_reg <= '0;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= $signed(ram_rdata) * coord;
        end
        if (state_reg == S_ACC)
        begin
            if (row_last)
            begin
                acc_reg <= '0;
                case (rcnt_reg)
                    2'd0:    cx_reg <= clip_sat;
                    2'd1:    cy_reg <= clip_sat;
                    default: cw_reg <= clip_sat;
                endcase
                if (rcnt_reg == 2'd2)
                begin
                    dq_reg         <= div_load(cx_reg);
                    neg_reg        <= cx_reg[DATA_W-1];
                    rem_reg        <= '0;
                    res_behind_reg <= !cw_pos;
                    res_x_reg      <= '0;
                    res_y_reg      <= '0;
                end
            end
            else
            begin
                acc_reg <= acc_sum;
            end
        end
        if (state_reg == S_DIV)
        begin
            if (div_last && !div_sel_reg)
            begin
                res_x_reg <= sx_val;
                dq_reg    <= div_load(cy_reg);
                neg_reg   <= cy_reg[DATA_W-1];
                rem_reg   <= '0;
            end
            else
            begin
                dq_reg  <= dq_next;
                rem_reg <= rem_next;
                if (div_last)
                begin
                    res_y_reg <= sy_val;
                end
            end
        end
        if (out_load)
        begin
            screen_x_reg <= res_x_reg;
            screen_y_reg <= res_y_reg;
            behind_reg   <= res_behind_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign screen_x      = screen_x_reg;
    assign screen_y      = screen_y_reg;
    assign behind_camera = behind_reg;

    a_mul_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |=> state_reg == S_ACC)
        else $error("multiply stage not followed by accumulate");

    a_project_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == FUNC_PROJECT) |=> state_reg == S_READ)
        else $error("accepted project beat did not start the matrix walk");

    a_div_w_positive: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> !cw_reg[DATA_W-1] && (cw_reg != '0))
        else $error("divide running with non-positive clip w");

    // The row counter steps past clip w once the walk is done, so only the
    // walk itself is checked.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_MUL || state_reg == S_ACC)
        |-> rcnt_reg != 2'd3)
        else $error("row counter past clip w row");

    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && behind_camera |-> (screen_x == '0) && (screen_y == '0))
        else $error("behind-camera result with nonzero coordinates");

endmodule
`default_nettype wire

FILE: rtl/core/ppts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ppts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: tb/ppts_screen_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Screen projection checker
// Watches the item and result channels of the point projection block. It
// keeps its own copy of the matrix and predicts each projected point. Every
// result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ppts_screen_checker
    import ppts_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic                       func,
    input  wire logic [IDX_W-1:0]           matrix_index,
    input  wire logic signed [DATA_W-1:0]   matrix_value,
    input  wire logic signed [DATA_W-1:0]   point_x,
    input  wire logic signed [DATA_W-1:0]   point_y,
    input  wire logic signed [DATA_W-1:0]   point_z,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic signed [DATA_W-1:0]   screen_x,
    input  wire logic signed [DATA_W-1:0]   screen_y,
    input  wire logic                       behind_camera,
    output int                              mismatch_count,
    output int                              pending_results
);

    localparam int ROW_X = 0;
    localparam int ROW_Y = 1;
    localparam int ROW_W = 3;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] sx;
        logic signed [DATA_W-1:0] sy;
        logic                     behind;
    } screen_point_t;

    logic signed [DATA_W-1:0] transform_copy [MAT_DEPTH];
    screen_point_t            expected_screen_q [$];
    int                       mismatch_total = 0;
    int                       queued = 0;

    assign mismatch_count  = mismatch_total;
    assign pending_results = queued;

    function automatic longint clamp32(input longint v);
        if (v > longint'(32'sh7fff_ffff))
            return longint'(32'sh7fff_ffff);
        if (v < -longint'(64'sd2147483648))
            return -longint'(64'sd2147483648);
        return v;
    endfunction

    // Column-major store: entry (col, row) sits at col * 4 + row.
    function automatic longint clip_component(input int row, input longint px,
                                              input longint py, input longint pz);
        longint e0, e1, e2, e3, acc;
        e0 = transform_copy[row];
        e1 = transform_copy[4 + row];
        e2 = transform_copy[8 + row];
        e3 = transform_copy[12 + row];
        acc = ((e0 * px) >>> FRAC_BITS) + ((e1 * py) >>> FRAC_BITS)
            + ((e2 * pz) >>> FRAC_BITS) + e3;
        return clamp32(acc);
    endfunction

    function automatic screen_point_t project_point(input logic signed [DATA_W-1:0] px,
                                                    input logic signed [DATA_W-1:0] py,
                                                    input logic signed [DATA_W-1:0] pz);
        longint        wx, wy, wz, cx, cy, cw, qx, qy, one;
        screen_point_t res;
        wx  = px;
        wy  = py;
        wz  = pz;
        one = longint'(1) <<< FRAC_BITS;
        cx  = clip_component(ROW_X, wx, wy, wz);
        cy  = clip_component(ROW_Y, wx, wy, wz);
        cw  = clip_component(ROW_W, wx, wy, wz);
        if (cw <= 0)
        begin
            res.sx     = '0;
            res.sy     = '0;
            res.behind = 1'b1;
        end
        else
        begin
            // Signed division truncates toward zero; the halving floors.
            qx = (cx * one) / cw;
            qy = (cy * one) / cw;
            res.sx     = DATA_W'(clamp32((qx + one) >>> 1));
            res.sy     = DATA_W'(clamp32((one - qy) >>> 1));
            res.behind = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        screen_point_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (func == FUNC_LOAD)
                    transform_copy[matrix_index] = matrix_value;
                else
                    expected_screen_q.push_back(project_point(point_x, point_y, point_z));
            end
            if (out_valid && out_ready)
            begin
                if (expected_screen_q.size() == 0)
                begin
                    if (mismatch_total < REPORT_LIMIT)
                        $display("%0t: unexpected screen beat x=%h y=%h behind=%b",
                                 $realtime, screen_x, screen_y, behind_camera);
                    mismatch_total++;
                end
                else
                begin
                    want = expected_screen_q.pop_front();
                    if (want.sx !== screen_x || want.sy !== screen_y
                        || want.behind !== behind_camera)
                    begin
                        if (mismatch_total < REPORT_LIMIT)
                            $display("%0t: screen mismatch, expected x=%h y=%h behind=%b, got x=%h y=%h behind=%b",
                                     $realtime, want.sx, want.sy, want.behind,
                                     screen_x, screen_y, behind_camera);
                        mismatch_total++;
                    end
                end
            end
            queued = expected_screen_q.size();
        end
    end

endmodule

FILE: tb/tb_point_projection_to_screen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point projection to screen testbench
// Loads matrices and streams project beats through the block with random
// gaps and output stalls: a directed opening on identity, saturation and
// behind-camera cases, then random matrix mixes with points of varied range.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_point_projection_to_screen;
    import ppts_pkg::*;

    localparam int TOTAL_ITEMS = 1050;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 200;

    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    typedef enum int {
        MAT_PERSPECTIVE,
        MAT_SMALL,
        MAT_WIDE,
        MAT_EXTREME
    } matrix_mix_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     func;
    logic [IDX_W-1:0]         matrix_index;
    logic signed [DATA_W-1:0] matrix_value;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] point_z;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] screen_x;
    logic signed [DATA_W-1:0] screen_y;
    logic                     behind_camera;

    int mismatch_count;
    int pending_results;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit in_burst    = 0;
    bit out_burst   = 0;

    point_projection_to_screen u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .matrix_index  (matrix_index),
        .matrix_value  (matrix_value),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .screen_x      (screen_x),
        .screen_y      (screen_y),
        .behind_camera (behind_camera)
    );

    ppts_screen_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .matrix_index    (matrix_index),
        .matrix_value    (matrix_value),
        .point_x         (point_x),
        .point_y         (point_y),
        .point_z         (point_z),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .screen_x        (screen_x),
        .screen_y        (screen_y),
        .behind_camera   (behind_camera),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Mostly short gaps, now and then a long one; none at all in a burst.
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(40, 200);
    endfunction

    function automatic logic [IDX_W-1:0] entry_index(input int col, input int row);
        return IDX_W'(col * 4 + row);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_span(input int half);
        int v;
        v = $urandom_range(0, 2 * half);
        return v - half;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_extreme();
        case ($urandom_range(0, 6))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return -1;
            4:       return 1;
            5:       return FIX_ONE;
            default: return -FIX_ONE;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return rand_span(64 * FIX_ONE);
        if (r < 9)
            return $urandom();
        return rand_extreme();
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_entry(input matrix_mix_t mix,
                                                            input int idx);
        int col, row;
        col = idx / 4;
        row = idx % 4;
        case (mix)
            MAT_PERSPECTIVE:
            begin
                // Row three makes w roughly -z, so points in front of the
                // camera have negative z and the divide path is exercised.
                if (row == 3)
                begin
                    if (col == 2)
                        return -FIX_ONE;
                    return rand_span(4096);
                end
                if (col == 3)
                    return rand_span(8 * FIX_ONE);
                return rand_span(2 * FIX_ONE);
            end
            MAT_SMALL: return rand_span(2 * FIX_ONE);
            MAT_WIDE:  return $urandom();
            default:   return rand_extreme();
        endcase
    endfunction

    task automatic send_beat(input logic f, input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] mv,
                             input logic signed [DATA_W-1:0] px,
                             input logic signed [DATA_W-1:0] py,
                             input logic signed [DATA_W-1:0] pz);
        int gap;
        gap = pick_gap(in_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func         <= f;
        matrix_index <= idx;
        matrix_value <= mv;
        point_x      <= px;
        point_y      <= py;
        point_z      <= pz;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Fields that the function ignores carry random junk.
    task automatic load_entry(input logic [IDX_W-1:0] idx,
                              input logic signed [DATA_W-1:0] val);
        send_beat(FUNC_LOAD, idx, val, $urandom(), $urandom(), $urandom());
    endtask

    task automatic project_beat(input logic signed [DATA_W-1:0] px,
                                input logic signed [DATA_W-1:0] py,
                                input logic signed [DATA_W-1:0] pz);
        send_beat(FUNC_PROJECT, IDX_W'($urandom_range(0, 15)), $urandom(), px, py, pz);
    endtask

    // A beat on either channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = pick_gap(out_burst);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    end

    initial
    begin
        matrix_mix_t mix;
        int          nproj;
        int          k;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_LOAD;
        matrix_index = '0;
        matrix_value = '0;
        point_x      = '0;
        point_y      = '0;
        point_z      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Identity on the rows that projection reads; row two is never used.
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (r != 2)
                    load_entry(entry_index(c, r), (c == r) ? FIX_ONE : '0);
        project_beat('0, '0, '0);
        project_beat(WORD_MAX, WORD_MIN, '0);
        project_beat(WORD_MIN, WORD_MAX, WORD_MAX);
        // Clip w of exactly zero, then negative, then positive from z.
        load_entry(entry_index(3, 3), '0);
        project_beat(FIX_ONE, FIX_ONE <<< 1, 3 * FIX_ONE);
        load_entry(entry_index(2, 3), -FIX_ONE);
        project_beat('0, '0, FIX_ONE);
        project_beat(FIX_ONE, -FIX_ONE, -(FIX_ONE <<< 1));
        // Saturated clip x over the smallest positive w.
        load_entry(entry_index(0, 0), WORD_MIN);
        load_entry(entry_index(3, 0), WORD_MAX);
        load_entry(entry_index(2, 3), '0);
        load_entry(entry_index(3, 3), 1);
        project_beat(WORD_MAX, '0, '0);

        while (items_sent < TOTAL_ITEMS)
        begin
            k = $urandom_range(0, 9);
            if (k < 4)
                mix = MAT_PERSPECTIVE;
            else if (k < 6)
                mix = MAT_SMALL;
            else if (k < 8)
                mix = MAT_WIDE;
            else
                mix = MAT_EXTREME;
            in_burst  = ($urandom_range(0, 3) == 0);
            out_burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < MAT_DEPTH; i++)
                load_entry(IDX_W'(i), rand_entry(mix, i));
            nproj = $urandom_range(15, 50);
            for (int j = 0; j < nproj; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    k = $urandom_range(0, MAT_DEPTH - 1);
                    load_entry(IDX_W'(k), rand_entry(mix, k));
                end
                else
                    project_beat(rand_coord(), rand_coord(), rand_coord());
            end
        end
        in_valid <= 1'b0;

        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ppts_pkg.sv
rtl/core/ppts_ram.sv
rtl/core/point_projection_to_screen.sv
tb/ppts_screen_checker.sv
tb/tb_point_projection_to_screen.sv
